// ===== hdl/tcc_pkg.sv =====
package tcc_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] MARK_CODE    = 8'h5F;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ATTR = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 3'd0,
    KIND_BACK  = 3'd1,
    KIND_CLEAR = 3'd2,
    KIND_MARK  = 3'd3,
    KIND_READ  = 3'd4
  } tcc_kind_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_BACK2,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_RESP
  } tcc_state_e;

  typedef enum logic [2:0] {
    WR_CUR_CHAR,
    WR_CUR_BLANK,
    WR_CUR_MARK,
    WR_COPY,
    WR_FILL_TEXT,
    WR_FILL_CLEAR,
    WR_FILL_RESET
  } tcc_wr_src_e;

  typedef enum logic {
    RD_CELL,
    RD_COPY
  } tcc_rd_src_e;

  typedef struct packed {
    logic        accept;
    logic        wr_en;
    tcc_wr_src_e wr_src;
    logic        rd_en;
    tcc_rd_src_e rd_src;
    logic        cur_put;
    logic        cur_back;
    logic        cnt_clr;
    logic        cnt_inc;
    logic        out_load;
  } tcc_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_newline;
    logic              scroll_needed;
    logic              read_ok;
    logic              cnt_zero;
    logic              cnt_copy_end;
    logic              cnt_last;
    logic              out_free;
  } tcc_sts_t;

endpackage

// ===== hdl/tcc_if.sv =====
interface tcc_req_if;
  logic                          valid;
  logic                          ready;
  logic [tcc_pkg::KIND_W-1:0]    kind;
  logic [tcc_pkg::CHAR_W-1:0]    char_code;
  logic [tcc_pkg::ROW_W-1:0]     read_row;
  logic [tcc_pkg::COL_W-1:0]     read_col;

  modport source (output valid, output kind, output char_code, output read_row,
                  output read_col, input ready);
  modport sink (input valid, input kind, input char_code, input read_row,
                input read_col, output ready);
endinterface

interface tcc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tcc_pkg::ROW_W-1:0]     cursor_row_out;
  logic [tcc_pkg::COL_W-1:0]     cursor_col_out;
  logic [tcc_pkg::CHAR_W-1:0]    cell_char;
  logic [tcc_pkg::ATTR_W-1:0]    cell_attr;

  modport source (output valid, output cursor_row_out, output cursor_col_out,
                  output cell_char, output cell_attr, input ready);
  modport sink (input valid, input cursor_row_out, input cursor_col_out,
                input cell_char, input cell_attr, output ready);
endinterface

// ===== hdl/tcc_ctrl.sv =====
module tcc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcc_pkg::tcc_sts_t sts_i,
  output tcc_pkg::tcc_cmd_t cmd_o
);

  tcc_pkg::tcc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcc_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcc_pkg::ST_INIT: begin
        if (sts_i.cnt_last) state_d = tcc_pkg::ST_IDLE;
      end
      tcc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tcc_pkg::ST_DECODE;
      end
      tcc_pkg::ST_DECODE: begin
        unique case (tcc_pkg::tcc_kind_e'(sts_i.kind))
          tcc_pkg::KIND_PUT: begin
            state_d = sts_i.scroll_needed ? tcc_pkg::ST_SCROLL : tcc_pkg::ST_RESP;
          end
          tcc_pkg::KIND_BACK:  state_d = tcc_pkg::ST_BACK2;
          tcc_pkg::KIND_CLEAR: state_d = tcc_pkg::ST_CLEAR;
          default:             state_d = tcc_pkg::ST_RESP;
        endcase
      end
      tcc_pkg::ST_BACK2: state_d = tcc_pkg::ST_RESP;
      tcc_pkg::ST_SCROLL: begin
        if (sts_i.cnt_copy_end) state_d = tcc_pkg::ST_FILL;
      end
      tcc_pkg::ST_FILL, tcc_pkg::ST_CLEAR: begin
        if (sts_i.cnt_last) state_d = tcc_pkg::ST_RESP;
      end
      tcc_pkg::ST_RESP: begin
        if (sts_i.out_free) state_d = tcc_pkg::ST_IDLE;
      end
      default: state_d = tcc_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.wr_src = tcc_pkg::WR_CUR_BLANK;
    cmd_o.rd_src = tcc_pkg::RD_CELL;
    in_ready_o = 1'b0;
    unique case (state_q)
      tcc_pkg::ST_INIT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_src  = tcc_pkg::WR_FILL_RESET;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.cnt_clr = sts_i.cnt_last;
      end
      tcc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
        cmd_o.cnt_clr = 1'b1;
      end
      tcc_pkg::ST_DECODE: begin
        unique case (tcc_pkg::tcc_kind_e'(sts_i.kind))
          tcc_pkg::KIND_PUT: begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_src  = sts_i.is_newline ? tcc_pkg::WR_CUR_BLANK : tcc_pkg::WR_CUR_CHAR;
            cmd_o.cur_put = 1'b1;
          end
          tcc_pkg::KIND_BACK: begin
            cmd_o.wr_en    = 1'b1;
            cmd_o.wr_src   = tcc_pkg::WR_CUR_BLANK;
            cmd_o.cur_back = 1'b1;
          end
          tcc_pkg::KIND_MARK: begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_src = tcc_pkg::WR_CUR_MARK;
          end
          tcc_pkg::KIND_READ: begin
            cmd_o.rd_en  = sts_i.read_ok;
            cmd_o.rd_src = tcc_pkg::RD_CELL;
          end
          default: begin
          end
        endcase
      end
      tcc_pkg::ST_BACK2: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = tcc_pkg::WR_CUR_BLANK;
      end
      tcc_pkg::ST_SCROLL: begin
        cmd_o.rd_en   = !sts_i.cnt_copy_end;
        cmd_o.rd_src  = tcc_pkg::RD_COPY;
        cmd_o.wr_en   = !sts_i.cnt_zero;
        cmd_o.wr_src  = tcc_pkg::WR_COPY;
        cmd_o.cnt_inc = !sts_i.cnt_copy_end;
      end
      tcc_pkg::ST_FILL: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_src  = tcc_pkg::WR_FILL_TEXT;
        cmd_o.cnt_inc = 1'b1;
      end
      tcc_pkg::ST_CLEAR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_src  = tcc_pkg::WR_FILL_CLEAR;
        cmd_o.cnt_inc = 1'b1;
      end
      tcc_pkg::ST_RESP: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcc_pkg::ST_IDLE) |-> (!cmd_o.wr_en && !cmd_o.rd_en))
    else $error("memory access while idle");

  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcc_pkg::ST_RESP && !sts_i.out_free) |=> (state_q == tcc_pkg::ST_RESP))
    else $error("response left while output slot full");

  a_accept_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == tcc_pkg::ST_DECODE))
    else $error("accepted request not decoded");

endmodule

// ===== hdl/tcc_datapath.sv =====
module tcc_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tcc_pkg::ATTR_W-1:0]       cfg_data_i,
  input  logic [tcc_pkg::KIND_W-1:0]       kind_i,
  input  logic [tcc_pkg::CHAR_W-1:0]       char_code_i,
  input  logic [tcc_pkg::ROW_W-1:0]        read_row_i,
  input  logic [tcc_pkg::COL_W-1:0]        read_col_i,
  input  tcc_pkg::tcc_cmd_t                cmd_i,
  output tcc_pkg::tcc_sts_t                sts_o,
  tcc_rsp_if.source                        rsp_o
);

  logic [tcc_pkg::ATTR_W-1:0] text_attr_q, clear_attr_q;
  logic [tcc_pkg::KIND_W-1:0] kind_q;
  logic [tcc_pkg::CHAR_W-1:0] char_q;
  logic [tcc_pkg::ROW_W-1:0]  rr_q;
  logic [tcc_pkg::COL_W-1:0]  rc_q;
  logic [tcc_pkg::ROW_W-1:0]  row_q, row_d;
  logic [tcc_pkg::COL_W-1:0]  col_q, col_d;
  logic [tcc_pkg::ADDR_W-1:0] cnt_q, cnt_d;
  logic                       out_valid_q;
  logic [tcc_pkg::ROW_W-1:0]  out_row_q;
  logic [tcc_pkg::COL_W-1:0]  out_col_q;
  logic [tcc_pkg::CHAR_W-1:0] out_char_q;
  logic [tcc_pkg::ATTR_W-1:0] out_attr_q;
  logic [tcc_pkg::CELL_W-1:0] rdata_q;

  logic [tcc_pkg::CELL_W-1:0] cell_mem [tcc_pkg::CELL_COUNT];

  logic [tcc_pkg::ADDR_W-1:0] cur_addr, read_addr, wr_addr, rd_addr;
  logic [tcc_pkg::CELL_W-1:0] wr_data;
  logic                       read_ok;
  logic                       last_col, last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q  <= tcc_pkg::RESET_ATTR;
      clear_attr_q <= tcc_pkg::RESET_ATTR;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tcc_pkg::CFG_TEXT_ATTR:  text_attr_q  <= cfg_data_i;
        tcc_pkg::CFG_CLEAR_ATTR: clear_attr_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      char_q <= char_code_i;
      rr_q   <= read_row_i;
      rc_q   <= read_col_i;
    end
  end

  assign cur_addr  = tcc_pkg::ADDR_W'(row_q * tcc_pkg::COLUMNS) + tcc_pkg::ADDR_W'(col_q);
  assign read_addr = tcc_pkg::ADDR_W'(rr_q * tcc_pkg::COLUMNS) + tcc_pkg::ADDR_W'(rc_q);
  assign read_ok   = (kind_q == tcc_pkg::KIND_READ) &&
                     (rr_q < tcc_pkg::ROW_W'(tcc_pkg::ROWS)) &&
                     (rc_q < tcc_pkg::COL_W'(tcc_pkg::COLUMNS));
  assign last_col  = (col_q == tcc_pkg::COL_W'(tcc_pkg::COLUMNS - 1));
  assign last_row  = (row_q == tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1));

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.cur_put) begin
      if ((char_q == tcc_pkg::NEWLINE_CODE) || last_col) begin
        col_d = '0;
        if (!last_row) row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end else if (cmd_i.cur_back) begin
      if (col_q != '0) begin
        col_d = col_q - 1'b1;
      end else if (row_q != '0) begin
        row_d = row_q - 1'b1;
        col_d = tcc_pkg::COL_W'(tcc_pkg::COLUMNS - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    wr_addr = cur_addr;
    wr_data = {text_attr_q, tcc_pkg::BLANK_CODE};
    case (cmd_i.wr_src)
      tcc_pkg::WR_CUR_CHAR:   wr_data = {text_attr_q, char_q};
      tcc_pkg::WR_CUR_BLANK:  wr_data = {text_attr_q, tcc_pkg::BLANK_CODE};
      tcc_pkg::WR_CUR_MARK:   wr_data = {text_attr_q, tcc_pkg::MARK_CODE};
      tcc_pkg::WR_COPY: begin
        wr_addr = cnt_q - 1'b1;
        wr_data = rdata_q;
      end
      tcc_pkg::WR_FILL_TEXT: begin
        wr_addr = cnt_q;
        wr_data = {text_attr_q, tcc_pkg::BLANK_CODE};
      end
      tcc_pkg::WR_FILL_CLEAR: begin
        wr_addr = cnt_q;
        wr_data = {clear_attr_q, tcc_pkg::BLANK_CODE};
      end
      tcc_pkg::WR_FILL_RESET: begin
        wr_addr = cnt_q;
        wr_data = {tcc_pkg::RESET_ATTR, tcc_pkg::BLANK_CODE};
      end
      default: begin
      end
    endcase
  end

  assign rd_addr = (cmd_i.rd_src == tcc_pkg::RD_COPY) ?
                   (cnt_q + tcc_pkg::ADDR_W'(tcc_pkg::COLUMNS)) : read_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) cell_mem[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rdata_q <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_char_q <= read_ok ? rdata_q[tcc_pkg::CHAR_W-1:0] : '0;
      out_attr_q <= read_ok ? rdata_q[tcc_pkg::CELL_W-1:tcc_pkg::CHAR_W] : '0;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.cursor_row_out = out_row_q;
  assign rsp_o.cursor_col_out = out_col_q;
  assign rsp_o.cell_char      = out_char_q;
  assign rsp_o.cell_attr      = out_attr_q;

  assign sts_o.kind          = kind_q;
  assign sts_o.is_newline    = (char_q == tcc_pkg::NEWLINE_CODE);
  assign sts_o.scroll_needed = last_row && ((char_q == tcc_pkg::NEWLINE_CODE) || last_col);
  assign sts_o.read_ok       = read_ok;
  assign sts_o.cnt_zero      = (cnt_q == '0);
  assign sts_o.cnt_copy_end  = (cnt_q == tcc_pkg::ADDR_W'(tcc_pkg::COPY_COUNT));
  assign sts_o.cnt_last      = (cnt_q == tcc_pkg::ADDR_W'(tcc_pkg::CELL_COUNT - 1));
  assign sts_o.out_free      = !out_valid_q || rsp_o.ready;

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < tcc_pkg::ROW_W'(tcc_pkg::ROWS))
    else $error("cursor row off screen");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < tcc_pkg::COL_W'(tcc_pkg::COLUMNS))
    else $error("cursor column off screen");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (wr_addr < tcc_pkg::ADDR_W'(tcc_pkg::CELL_COUNT)))
    else $error("write outside screen store");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || rsp_o.ready))
    else $error("result overwritten before taken");

endmodule

// ===== hdl/text_console_cursor_engine.sv =====
// Flow: every request passes decode, then waits in the response state for a free result
// slot; backspace adds a second blank write; clear writes every cell, one memory write a cycle;
// put char that scrolls copies the lower 24 rows up one row, then blanks the bottom row.
// Throughput: one request at a time; the next is taken the cycle after a result is loaded.
// Reset: async active low; an init pass then blanks every cell of the store before any request.
module text_console_cursor_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tcc_pkg::ATTR_W-1:0]    cfg_data_i,
  tcc_req_if.sink                       req_i,
  tcc_rsp_if.source                     rsp_o
);

  tcc_pkg::tcc_cmd_t cmd;
  tcc_pkg::tcc_sts_t sts;
  logic              in_ready;

  assign req_i.ready = in_ready;

  tcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .kind_i      (req_i.kind),
    .char_code_i (req_i.char_code),
    .read_row_i  (req_i.read_row),
    .read_col_i  (req_i.read_col),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule
